@@ hdl/atu_pkg.sv @@
// Shared types, command codes and CORDIC constants for the affine transform unit.
`default_nettype none
package atu_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam logic [2:0] CMD_IDENTITY  = 3'd0;
  localparam logic [2:0] CMD_SCALE     = 3'd1;
  localparam logic [2:0] CMD_SHIFT     = 3'd2;
  localparam logic [2:0] CMD_ROTATE    = 3'd3;
  localparam logic [2:0] CMD_TRANSFORM = 3'd4;

  // angle reduction datapath
  localparam int RED_W     = 58;
  localparam int RED_STEPS = 23;
  localparam int RED_CNT_W = 5;
  // CORDIC x/y/z datapath in Q30
  localparam int CW        = 34;

  localparam logic signed [RED_W-1:0] Q30_TWO_PI  = 58'sd6746518852;
  localparam logic signed [RED_W-1:0] Q30_PI      = 58'sd3373259426;
  localparam logic signed [RED_W-1:0] Q30_HALF_PI = 58'sd1686629713;
  localparam logic signed [CW-1:0]    Q30_GAIN    = 34'sd652032874;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] arg_w;
  } atu_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_w;
    logic               saturated;
  } atu_out_t;

  // operand feed into a lane
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [1:0] col;
  } lane_ctl_t;

  // finished dot product out of a lane
  typedef struct packed {
    logic               done;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               sat;
  } lane_res_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/atu_lane.sv @@
// One multiply-accumulate lane: three-term dot product, rounded and saturated.
`default_nettype none
module atu_lane #(
  parameter int FRACTION_BITS = atu_pkg::FRACTION_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  atu_pkg::lane_ctl_t       ctl,
  input  wire logic signed [31:0]  a,
  input  wire logic signed [31:0]  b,
  output atu_pkg::lane_res_t       res
);

  localparam logic signed [66:0] HALF_LSB = 67'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [66:0] S32_MAX  = 67'sd2147483647;
  localparam logic signed [66:0] S32_MIN  = -67'sd2147483648;

  logic signed [63:0] prod;
  atu_pkg::lane_ctl_t pctl;
  logic signed [65:0] acc;
  logic               done;
  logic [1:0]         dcol;
  logic signed [66:0] rnd;
  logic signed [66:0] scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      pctl <= '0;
      done <= 1'b0;
    end else begin
      pctl <= ctl;
      done <= pctl.valid && pctl.last;
    end
    prod <= a * b;
    dcol <= pctl.col;
    if (pctl.valid) begin
      if (pctl.first) acc <= 66'(prod);
      else acc <= acc + 66'(prod);
    end
  end

  // exact sum, then round half up at the fraction point
  assign rnd    = 67'(acc) + HALF_LSB;
  assign scaled = rnd >>> FRACTION_BITS;

  always_comb begin
    res.done = done;
    res.col  = dcol;
    res.sat  = 1'b0;
    if (scaled > S32_MAX) begin
      res.value = 32'sh7FFFFFFF;
      res.sat   = 1'b1;
    end else if (scaled < S32_MIN) begin
      res.value = 32'sh80000000;
      res.sat   = 1'b1;
    end else begin
      res.value = scaled[31:0];
    end
  end

endmodule
`default_nettype wire

@@ hdl/atu_cordic.sv @@
// Iterative angle reduction and rotation-mode CORDIC giving cosine and sine.
`default_nettype none
module atu_cordic #(
  parameter int FRACTION_BITS = atu_pkg::FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS  = atu_pkg::CORDIC_STEPS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire logic signed [31:0]  angle,
  output logic                     done,
  output logic signed [31:0]       cos_out,
  output logic signed [31:0]       sin_out
);

  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam int SH     = 30 - FRACTION_BITS;
  localparam int CW     = atu_pkg::CW;
  localparam int RED_W  = atu_pkg::RED_W;
  localparam logic signed [CW:0] HALF_LSB = (CW+1)'(1) <<< (SH - 1);
  localparam logic signed [RED_W-1:0] OFFSET =
    atu_pkg::Q30_TWO_PI <<< (atu_pkg::RED_STEPS - 1);

  typedef enum logic [4:0] {
    C_IDLE   = 5'b00001,
    C_REDUCE = 5'b00010,
    C_FOLD   = 5'b00100,
    C_ITER   = 5'b01000,
    C_FIN    = 5'b10000
  } cstate_t;

  cstate_t                  state;
  logic signed [RED_W-1:0]  r;
  logic [atu_pkg::RED_CNT_W-1:0] bcnt;
  logic signed [RED_W-1:0]  sub;
  logic signed [RED_W-1:0]  rz;
  logic signed [CW-1:0]     x, y, z;
  logic signed [CW-1:0]     dx, dy, at;
  logic signed [CW-1:0]     xf, yf;
  logic signed [CW:0]       xr, yr;
  logic [ITER_W-1:0]        icnt;
  logic                     flip;

  assign sub = atu_pkg::Q30_TWO_PI <<< bcnt;
  assign rz  = (r > atu_pkg::Q30_PI) ? r - atu_pkg::Q30_TWO_PI : r;
  assign dx  = x >>> icnt;
  assign dy  = y >>> icnt;
  assign at  = atu_pkg::atan_q30(5'(icnt));
  assign xf  = flip ? -x : x;
  assign yf  = flip ? -y : y;
  assign xr  = (CW+1)'(xf) + HALF_LSB;
  assign yr  = (CW+1)'(yf) + HALF_LSB;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            // offset by a multiple of 2*pi keeps the value positive
            r     <= (RED_W'(angle) <<< SH) + OFFSET;
            bcnt  <= atu_pkg::RED_CNT_W'(atu_pkg::RED_STEPS - 1);
            state <= C_REDUCE;
          end
        end
        C_REDUCE: begin
          if (r >= sub) r <= r - sub;
          if (bcnt == '0) state <= C_FOLD;
          bcnt <= bcnt - 1'b1;
        end
        C_FOLD: begin
          if (rz > atu_pkg::Q30_HALF_PI) begin
            z    <= CW'(rz - atu_pkg::Q30_PI);
            flip <= 1'b1;
          end else if (rz < -atu_pkg::Q30_HALF_PI) begin
            z    <= CW'(rz + atu_pkg::Q30_PI);
            flip <= 1'b1;
          end else begin
            z    <= CW'(rz);
            flip <= 1'b0;
          end
          x     <= atu_pkg::Q30_GAIN;
          y     <= '0;
          icnt  <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[CW-1]) begin
            x <= x - dy;
            y <= y + dx;
            z <= z - at;
          end else begin
            x <= x + dy;
            y <= y - dx;
            z <= z + at;
          end
          if (icnt == ITER_W'(CORDIC_STEPS - 1)) state <= C_FIN;
          icnt <= icnt + 1'b1;
        end
        C_FIN: begin
          cos_out <= 32'(xr >>> SH);
          sin_out <= 32'(yr >>> SH);
          done    <= 1'b1;
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/affine_transform_unit.sv @@
// Top level: 3x3 affine transform matrix with three MAC lanes and a CORDIC unit.
`default_nettype none
// Holds a 3x3 Q16.16 matrix and executes one command per transaction.
// Three lanes, one per matrix row, each run a 32x32 multiply-accumulate; the
// merge logic gathers their results into the matrix or into the result
// register. Identity and unused codes finish without leaving the idle state.
// Scale and shift feed the lanes, drain them and commit the new matrix. Rotate
// first runs angle reduction, setup and the iterations of the CORDIC unit.
// Transform point feeds and drains the lanes, loads the result register and
// yields one result transaction; it waits in a hold state while the previous
// result is still stalled. One command is processed at a time.
module affine_transform_unit #(
  parameter int FRACTION_BITS = atu_pkg::FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS  = atu_pkg::CORDIC_STEPS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  output logic              cmd_stall,
  input  atu_pkg::atu_in_t  cmd_item,
  output logic              res_valid,
  input  wire               res_stall,
  output atu_pkg::atu_out_t res_item
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_FEED   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_COMMIT = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

  state_t             state;
  logic [2:0]         cmd_q;
  logic signed [31:0] ax, ay, aw;
  logic signed [31:0] cos_q, sin_q;
  logic [1:0]         kcnt, jcnt;
  logic [1:0]         last_col;
  logic               is_point;
  logic               opsat;
  logic               sticky;
  logic               accept;
  logic               load_ident;
  logic               commit;
  logic               load_out;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [31:0] cordic_c, cordic_s;
  logic signed [31:0] b_op;
  logic               any_sat;
  atu_pkg::lane_ctl_t ctl;
  atu_pkg::lane_res_t lres [3];
  logic signed [31:0] rval [3][3];

  function automatic logic signed [31:0] elem(
    input logic [2:0]         cmd,
    input logic [1:0]         k,
    input logic [1:0]         j,
    input logic signed [31:0] ex,
    input logic signed [31:0] ey,
    input logic signed [31:0] cv,
    input logic signed [31:0] sv
  );
    logic signed [31:0] v;
    v = (k == j) ? ONE : 32'sd0;
    case (cmd)
      atu_pkg::CMD_SCALE: begin
        if (k == 2'd0 && j == 2'd0) v = ex;
        if (k == 2'd1 && j == 2'd1) v = ey;
      end
      atu_pkg::CMD_SHIFT: begin
        if (k == 2'd0 && j == 2'd2) v = ex;
        if (k == 2'd1 && j == 2'd2) v = ey;
      end
      atu_pkg::CMD_ROTATE: begin
        if (k == 2'd0 && j == 2'd0) v = cv;
        if (k == 2'd0 && j == 2'd1) v = -sv;
        if (k == 2'd1 && j == 2'd0) v = sv;
        if (k == 2'd1 && j == 2'd1) v = cv;
      end
      default: v = (k == j) ? ONE : 32'sd0;
    endcase
    return v;
  endfunction

  assign cmd_stall    = (state != S_IDLE);
  assign accept       = cmd_valid && !cmd_stall;
  assign load_ident   = accept && cmd_item.command == atu_pkg::CMD_IDENTITY;
  assign cordic_start = accept && cmd_item.command == atu_pkg::CMD_ROTATE;
  assign is_point     = (cmd_q == atu_pkg::CMD_TRANSFORM);
  assign last_col     = is_point ? 2'd0 : 2'd2;
  assign commit       = (state == S_COMMIT);
  assign load_out     = (state == S_HOLD) && (!res_valid || !res_stall);
  assign any_sat      = (lres[0].done && lres[0].sat) || (lres[1].done && lres[1].sat)
                     || (lres[2].done && lres[2].sat);

  always_comb begin
    if (is_point) begin
      case (kcnt)
        2'd0:    b_op = ax;
        2'd1:    b_op = ay;
        default: b_op = aw;
      endcase
    end else begin
      b_op = elem(cmd_q, kcnt, jcnt, ax, ay, cos_q, sin_q);
    end
    ctl.valid = (state == S_FEED);
    ctl.first = (kcnt == 2'd0);
    ctl.last  = (kcnt == 2'd2);
    ctl.col   = jcnt;
  end

  atu_cordic #(
    .FRACTION_BITS (FRACTION_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (cmd_item.arg_x),
    .done    (cordic_done),
    .cos_out (cordic_c),
    .sin_out (cordic_s)
  );

  for (genvar i = 0; i < 3; i++) begin : g_row
    logic signed [31:0] row [3];

    atu_lane #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .a   (row[kcnt]),
      .b   (b_op),
      .res (lres[i])
    );

    // matrix row and merge buffer for this lane
    always_ff @(posedge clk) begin
      if (rst || load_ident) begin
        for (int k = 0; k < 3; k++) begin
          row[k] <= (k == i) ? ONE : 32'sd0;
        end
      end else if (commit) begin
        for (int k = 0; k < 3; k++) begin
          row[k] <= rval[i][k];
        end
      end
      if (lres[i].done) rval[i][lres[i].col] <= lres[i].value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sticky    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (load_out) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_item.command;
            ax    <= cmd_item.arg_x;
            ay    <= cmd_item.arg_y;
            aw    <= cmd_item.arg_w;
            kcnt  <= '0;
            jcnt  <= '0;
            opsat <= 1'b0;
            case (cmd_item.command)
              atu_pkg::CMD_SCALE,
              atu_pkg::CMD_SHIFT,
              atu_pkg::CMD_TRANSFORM: state <= S_FEED;
              atu_pkg::CMD_ROTATE:    state <= S_CORDIC;
              default:                state <= S_IDLE;
            endcase
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            cos_q <= cordic_c;
            sin_q <= cordic_s;
            state <= S_FEED;
          end
        end
        S_FEED: begin
          if (kcnt == 2'd2) begin
            kcnt <= '0;
            jcnt <= jcnt + 1'b1;
            if (jcnt == last_col) state <= S_DRAIN;
          end else begin
            kcnt <= kcnt + 1'b1;
          end
        end
        S_DRAIN: begin
          if (lres[0].done && lres[0].col == last_col) begin
            state <= is_point ? S_HOLD : S_COMMIT;
          end
        end
        S_COMMIT: begin
          sticky <= sticky | opsat;
          state  <= S_IDLE;
        end
        S_HOLD: begin
          if (load_out) begin
            sticky <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (any_sat) opsat <= 1'b1;
    end
    if (load_out) begin
      res_item.out_x     <= rval[0][0];
      res_item.out_y     <= rval[1][0];
      res_item.out_w     <= rval[2][0];
      res_item.saturated <= sticky | opsat;
    end
  end

  a_res_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_HOLD))
    else $error("result raised outside hold state");

  a_lane_done_window: assert property (@(posedge clk) disable iff (rst)
    lres[0].done |-> $past(state == S_FEED || state == S_DRAIN))
    else $error("lane finished without a feed");

  a_sticky_cleared: assert property (@(posedge clk) disable iff (rst)
    load_out |=> !sticky && res_valid)
    else $error("saturation flag not cleared after point result");

endmodule
`default_nettype wire

@@ verif/atu_checker.sv @@
// Checker for the affine transform unit: predicts point results and compares them.
`timescale 1ns / 1ps
module atu_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  input  wire               cmd_stall,
  input  atu_pkg::atu_in_t  cmd_item,
  input  wire               res_valid,
  input  wire               res_stall,
  input  atu_pkg::atu_out_t res_item,
  output int                fail_count,
  output int                pending,
  output int                points_seen
);

  localparam int FB = atu_pkg::FRACTION_BITS_DEF;

  logic signed [31:0] mat [9];
  bit                 sat_flag;
  atu_pkg::atu_out_t  expected_points [$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // three exact products, round to nearest (ties up), saturate
  function automatic logic signed [31:0] dot3(input logic signed [31:0] a0, a1, a2,
                                              input logic signed [31:0] b0, b1, b2);
    longint hi;
    longint lo;
    longint p;
    longint h;
    hi = 0;
    lo = longint'(1) << (FB - 1);
    p = longint'(a0) * longint'(b0); h = fshift(p, FB); hi += h; lo += p - (h << FB);
    p = longint'(a1) * longint'(b1); h = fshift(p, FB); hi += h; lo += p - (h << FB);
    p = longint'(a2) * longint'(b2); h = fshift(p, FB); hi += h; lo += p - (h << FB);
    hi += fshift(lo, FB);
    if (hi > 64'sd2147483647) begin
      sat_flag = 1;
      return 32'sh7fffffff;
    end
    if (hi < -64'sd2147483648) begin
      sat_flag = 1;
      return 32'sh80000000;
    end
    return hi[31:0];
  endfunction

  function automatic void compose(input logic signed [31:0] e [9]);
    logic signed [31:0] r [9];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i*3+j] = dot3(mat[i*3], mat[i*3+1], mat[i*3+2], e[j], e[3+j], e[6+j]);
    mat = r;
  endfunction

  function automatic void unit_matrix(output logic signed [31:0] m [9]);
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? (32'sd1 <<< FB) : 32'sd0;
  endfunction

  function automatic void angle_cos_sin(input logic signed [31:0] ang,
                                        output logic signed [31:0] c, s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * (longint'(1) << (30 - FB));
    x = atu_pkg::Q30_GAIN;
    y = 0;
    flip = 0;
    z = z % atu_pkg::Q30_TWO_PI;
    if (z < 0) z += atu_pkg::Q30_TWO_PI;
    if (z > atu_pkg::Q30_PI) z -= atu_pkg::Q30_TWO_PI;
    if (z > atu_pkg::Q30_HALF_PI) begin
      z -= atu_pkg::Q30_PI;
      flip = 1;
    end else if (z < -atu_pkg::Q30_HALF_PI) begin
      z += atu_pkg::Q30_PI;
      flip = 1;
    end
    for (int i = 0; i < atu_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        z -= atu_pkg::atan_q30(i[4:0]);
      end else begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        z += atu_pkg::atan_q30(i[4:0]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = 32'(fshift(x + (longint'(1) << (29 - FB)), 30 - FB));
    s = 32'(fshift(y + (longint'(1) << (29 - FB)), 30 - FB));
  endfunction

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic signed [31:0] e [9];
    logic signed [31:0] c, s;
    atu_pkg::atu_out_t exp_pt;
    if (rst) begin
      unit_matrix(mat);
      sat_flag = 0;
      expected_points.delete();
      fail_count = 0;
      points_seen = 0;
    end else begin
      if (res_valid && !res_stall) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          report("point result with none expected");
        end else begin
          exp_pt = expected_points.pop_front();
          if (res_item.out_x !== exp_pt.out_x)
            report($sformatf("out_x %h exp %h", res_item.out_x, exp_pt.out_x));
          if (res_item.out_y !== exp_pt.out_y)
            report($sformatf("out_y %h exp %h", res_item.out_y, exp_pt.out_y));
          if (res_item.out_w !== exp_pt.out_w)
            report($sformatf("out_w %h exp %h", res_item.out_w, exp_pt.out_w));
          if (res_item.saturated !== exp_pt.saturated)
            report($sformatf("saturated %b exp %b", res_item.saturated, exp_pt.saturated));
        end
      end
      if (cmd_valid && !cmd_stall) begin
        unit_matrix(e);
        case (cmd_item.command)
          atu_pkg::CMD_IDENTITY: unit_matrix(mat);
          atu_pkg::CMD_SCALE: begin
            e[0] = cmd_item.arg_x;
            e[4] = cmd_item.arg_y;
            compose(e);
          end
          atu_pkg::CMD_SHIFT: begin
            e[2] = cmd_item.arg_x;
            e[5] = cmd_item.arg_y;
            compose(e);
          end
          atu_pkg::CMD_ROTATE: begin
            angle_cos_sin(cmd_item.arg_x, c, s);
            e[0] = c; e[1] = -s; e[3] = s; e[4] = c;
            compose(e);
          end
          atu_pkg::CMD_TRANSFORM: begin
            for (int i = 0; i < 3; i++) begin
              c = dot3(mat[i*3], mat[i*3+1], mat[i*3+2],
                       cmd_item.arg_x, cmd_item.arg_y, cmd_item.arg_w);
              if (i == 0) exp_pt.out_x = c;
              else if (i == 1) exp_pt.out_y = c;
              else exp_pt.out_w = c;
            end
            exp_pt.saturated = sat_flag;
            sat_flag = 0;
            expected_points.push_back(exp_pt);
          end
          default: ;
        endcase
      end
    end
    pending = expected_points.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    points_seen = 0;
  end
endmodule

@@ verif/testbench.sv @@
// Top of the affine transform unit testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT  = 600000;

  logic              clk = 0;
  logic              rst = 1;
  logic              cmd_valid = 0;
  atu_pkg::atu_in_t  cmd_item = '0;
  logic              res_stall = 0;
  logic              cmd_stall;
  logic              res_valid;
  atu_pkg::atu_out_t res_item;
  int                fail_count, pending, points_seen;
  int                cycles = 0;
  int                stall_mode = 0;

  always #5 clk = ~clk;

  affine_transform_unit i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
  );

  atu_checker i_checker (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .fail_count(fail_count), .pending(pending), .points_seen(points_seen)
  );

  // receiver stalls: phases of none, light, heavy
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: res_stall <= 0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= ($urandom_range(0, 3) != 0);
    endcase
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
      default: return $signed(32'($urandom_range(0, 32'h2ffff))) - 32'sh18000;
    endcase
  endfunction

  // one command transaction; gaps are run by the caller
  task automatic send(input logic [2:0] op, input logic signed [31:0] ax, ay, aw);
    cmd_item <= '{command: op, arg_x: ax, arg_y: ay, arg_w: aw};
    cmd_valid <= 1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic pause(input int n);
    cmd_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  logic signed [31:0] one;
  int burst;
  logic [2:0] op;

  initial begin
    one = 32'sd1 <<< atu_pkg::FRACTION_BITS_DEF;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, all commands, unused codes, sticky flag behavior
    send(atu_pkg::CMD_TRANSFORM, one, one, one);
    send(atu_pkg::CMD_TRANSFORM, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send(atu_pkg::CMD_TRANSFORM, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send(atu_pkg::CMD_TRANSFORM, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send(atu_pkg::CMD_SCALE, 32'sh00020000, 32'shfffe8000, 0);
    send(atu_pkg::CMD_SHIFT, 32'sh7fffffff, 32'sh80000000, 32'sh1234);
    send(atu_pkg::CMD_TRANSFORM, one, -one, one);
    send(atu_pkg::CMD_IDENTITY, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
    send(atu_pkg::CMD_TRANSFORM, 0, 0, 0);
    send(atu_pkg::CMD_SCALE, 32'sh7fffffff, 32'sh7fffffff, 0);
    send(atu_pkg::CMD_IDENTITY, 0, 0, 0);
    send(atu_pkg::CMD_TRANSFORM, one, one, one);
    send(3'd5, 32'sh7fffffff, 0, 0);
    send(3'd6, 0, 32'sh80000000, 0);
    send(3'd7, -1, -1, -1);
    send(atu_pkg::CMD_ROTATE, 32'sh7fffffff, 0, 0);
    send(atu_pkg::CMD_ROTATE, 32'sh80000000, 0, 0);
    send(atu_pkg::CMD_ROTATE, 32'sh0001921f, 0, 0);
    send(atu_pkg::CMD_ROTATE, 32'shfffe6de1, 0, 0);
    send(atu_pkg::CMD_ROTATE, 32'sh00032440, 0, 0);
    send(atu_pkg::CMD_ROTATE, 0, 0, 0);
    send(atu_pkg::CMD_TRANSFORM, one, 32'sh00028000, one);
    send(atu_pkg::CMD_IDENTITY, 0, 0, 0);
    for (int n = 0; n < RANDOM_ITEMS; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        case ($urandom_range(0, 19))
          0: op = atu_pkg::CMD_IDENTITY;
          1, 2: op = atu_pkg::CMD_SCALE;
          3, 4: op = atu_pkg::CMD_SHIFT;
          5, 6, 7: op = atu_pkg::CMD_ROTATE;
          8: op = 3'($urandom_range(5, 7));
          default: op = atu_pkg::CMD_TRANSFORM;
        endcase
        send(op, rand_value(), rand_value(), rand_value());
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
    cmd_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("ran %0d directed and about %0d random commands", 23, RANDOM_ITEMS);
    $display("%0d point results checked in %0d cycles", points_seen, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
